// ===== hdl/pfra_pkg.sv =====
// Package with the shared types, codes and constants of the page frame allocator.
`default_nettype none

package pfra_pkg;

    localparam int PFRA_MAX_PAGES   = 65536;
    localparam int PFRA_COUNT_LIMIT = 255;
    localparam int PFRA_INDEX_SPAN  = 65536;

    localparam logic [16:0] PFRA_FREE_MAX    = 17'h1FFFF;
    localparam logic [15:0] PFRA_START_RESET = 16'd256;
    localparam logic [16:0] PFRA_TOTAL_RESET = 17'h10000;

    localparam logic CFG_START_PAGE  = 1'b0;
    localparam logic CFG_TOTAL_PAGES = 1'b1;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_SHARE   = 3'd2,
        CMD_QUERY   = 3'd3,
        CMD_INIT    = 3'd4
    } pfra_op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_RANGE    = 3'd2,
        ST_UNUSED   = 3'd3,
        ST_OVERFLOW = 3'd4
    } pfra_status_t;

    typedef enum logic [2:0] {
        RES_NONE   = 3'd0,
        RES_REJECT = 3'd1,
        RES_ALLOC  = 3'd2,
        RES_RMW    = 3'd3,
        RES_INIT   = 3'd4
    } pfra_res_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] page_index;
    } pfra_in_t;

    typedef struct packed {
        logic [15:0] page_out;
        logic [7:0]  ref_count;
        logic [16:0] free_count;
        logic [2:0]  status;
    } pfra_out_t;

    typedef struct packed {
        logic      load_item;
        logic      clr_start;
        logic      clr_step;
        logic      scan_step;
        logic      rmw_read;
        pfra_res_t res_sel;
        logic      out_load;
    } pfra_cmd_t;

    typedef struct packed {
        logic in_alloc;
        logic in_init;
        logic in_rmw;
        logic alloc_empty;
        logic clr_last;
        logic scan_found;
        logic scan_exhausted;
        logic out_free;
    } pfra_stat_t;

endpackage

`default_nettype wire

// ===== hdl/pfra_dp.sv =====
// Datapath of the page frame allocator: count memory, scan pointer, counters and result regs.
`default_nettype none

module pfra_dp
    import pfra_pkg::*;
#(
    parameter int MAX_PAGES = PFRA_MAX_PAGES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pfra_in_t    in_item,
    output pfra_out_t        out_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire pfra_cmd_t   cmd,
    output pfra_stat_t       stat
);

    localparam int MEM_DEPTH = (MAX_PAGES > PFRA_INDEX_SPAN) ? PFRA_INDEX_SPAN : MAX_PAGES;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [16:0] LIM_MAX  = 17'(MEM_DEPTH);
    localparam logic [AW-1:0] CLR_END = AW'(MEM_DEPTH - 1);

    logic [7:0]    mem [MEM_DEPTH];
    logic [7:0]    rd_data_reg;

    logic [15:0]   start_reg;
    logic [16:0]   total_reg;
    logic [16:0]   free_reg;
    logic [16:0]   free_next;
    logic [AW-1:0] clr_ptr_reg;
    logic [16:0]   scan_ptr_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          pend_vld_reg;
    logic          out_vld_reg;

    logic [2:0]    cmd_reg;
    logic [15:0]   idx_reg;
    pfra_out_t     res_reg;
    pfra_out_t     res_next;
    pfra_out_t     out_reg;

    logic [16:0]   lim;
    logic [16:0]   start_ext;
    logic [16:0]   in_idx_ext;
    logic          scan_issue;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [8:0]    cur_inc;
    logic [7:0]    cur_dec;

    always_comb
    begin
        lim        = (total_reg > LIM_MAX) ? LIM_MAX : total_reg;
        start_ext  = {1'b0, start_reg};
        in_idx_ext = {1'b0, in_item.page_index};
        scan_issue = cmd.scan_step && (scan_ptr_reg < lim);
        cur_inc    = {1'b0, rd_data_reg} + 9'd1;
        cur_dec    = rd_data_reg - 8'd1;

        stat.in_alloc       = (in_item.cmd == CMD_ALLOC);
        stat.in_init        = (in_item.cmd == CMD_INIT);
        stat.in_rmw         = ((in_item.cmd == CMD_RELEASE) || (in_item.cmd == CMD_SHARE) ||
                               (in_item.cmd == CMD_QUERY)) &&
                              (in_idx_ext >= start_ext) && (in_idx_ext < lim);
        stat.alloc_empty    = (start_ext >= lim);
        stat.clr_last       = (clr_ptr_reg == CLR_END);
        stat.scan_found     = pend_vld_reg && (rd_data_reg == 8'd0);
        stat.scan_exhausted = !pend_vld_reg && (scan_ptr_reg >= lim);
        stat.out_free       = !out_vld_reg || !out_stall;

        mem_re    = cmd.scan_step || cmd.rmw_read;
        mem_raddr = cmd.scan_step ? scan_ptr_reg[AW-1:0] : idx_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = clr_ptr_reg;
        mem_wdata = 8'd0;
        free_next = free_reg;

        res_next.page_out  = idx_reg;
        res_next.ref_count = 8'd0;
        res_next.status    = ST_OK;

        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end

        case (cmd.res_sel)
            RES_REJECT:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    res_next.page_out = 16'd0;
                    res_next.status   = ST_OOM;
                end
                else
                begin
                    res_next.status = ST_RANGE;
                end
            end
            RES_ALLOC:
            begin
                mem_we             = 1'b1;
                mem_waddr          = pend_addr_reg;
                mem_wdata          = 8'd1;
                free_next          = (free_reg == 17'd0) ? 17'd0 : free_reg - 17'd1;
                res_next.page_out  = 16'(pend_addr_reg);
                res_next.ref_count = 8'd1;
            end
            RES_RMW:
            begin
                mem_waddr = idx_reg[AW-1:0];
                if (cmd_reg == CMD_QUERY)
                begin
                    res_next.ref_count = rd_data_reg;
                end
                else if (rd_data_reg == 8'd0)
                begin
                    res_next.status = ST_UNUSED;
                end
                else if (cmd_reg == CMD_RELEASE)
                begin
                    mem_we             = 1'b1;
                    mem_wdata          = cur_dec;
                    res_next.ref_count = cur_dec;
                    if ((cur_dec == 8'd0) && (free_reg < PFRA_FREE_MAX))
                    begin
                        free_next = free_reg + 17'd1;
                    end
                end
                else if (cur_inc >= 9'(PFRA_COUNT_LIMIT))
                begin
                    res_next.status    = ST_OVERFLOW;
                    res_next.ref_count = rd_data_reg;
                end
                else
                begin
                    mem_we             = 1'b1;
                    mem_wdata          = cur_inc[7:0];
                    res_next.ref_count = cur_inc[7:0];
                end
            end
            RES_INIT:
            begin
                free_next         = (lim > start_ext) ? lim - start_ext : 17'd0;
                res_next.page_out = 16'd0;
            end
            default:
            begin
                free_next = free_reg;
            end
        endcase

        res_next.free_count = free_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= PFRA_START_RESET;
            total_reg    <= PFRA_TOTAL_RESET;
            free_reg     <= 17'd0;
            clr_ptr_reg  <= '0;
            scan_ptr_reg <= 17'd0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_START_PAGE))
            begin
                start_reg <= cfg_data[15:0];
            end
            if (cfg_we && (cfg_index == CFG_TOTAL_PAGES))
            begin
                total_reg <= cfg_data;
            end
            free_reg <= free_next;
            if (cmd.clr_start)
            begin
                clr_ptr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_ptr_reg <= stat.clr_last ? '0 : clr_ptr_reg + AW'(1);
            end
            if (cmd.load_item)
            begin
                scan_ptr_reg <= start_ext;
            end
            else if (scan_issue)
            begin
                scan_ptr_reg <= scan_ptr_reg + 17'd1;
            end
            pend_vld_reg <= scan_issue;
            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg <= in_item.cmd;
            idx_reg <= in_item.page_index;
        end
        if (scan_issue)
        begin
            pend_addr_reg <= scan_ptr_reg[AW-1:0];
        end
        if (cmd.res_sel != RES_NONE)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_item  = out_reg;
    assign out_valid = out_vld_reg;

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.scan_found |-> (17'(pend_addr_reg) >= start_ext) && (17'(pend_addr_reg) < lim))
        else $error("scan hit outside the managed range");

    a_alloc_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_sel == RES_ALLOC) |-> pend_vld_reg && (rd_data_reg == 8'd0))
        else $error("allocation claimed a page in use");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_vld_reg || !out_stall))
        else $error("result overwrote an item not yet taken");

endmodule

`default_nettype wire

// ===== hdl/pfra_ctrl.sv =====
// Controller state machine of the page frame allocator.
`default_nettype none

module pfra_ctrl
    import pfra_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire pfra_stat_t stat,
    output pfra_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_RST_CLR  = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_RD       = 8'b0000_1000,
        S_MOD      = 8'b0001_0000,
        S_INIT_CLR = 8'b0010_0000,
        S_REJ      = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } pfra_state_t;

    pfra_state_t state_reg;
    pfra_state_t state_next;
    logic        accept;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.load_item = 1'b0;
        cmd.clr_start = 1'b0;
        cmd.clr_step  = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.rmw_read  = 1'b0;
        cmd.res_sel   = RES_NONE;
        cmd.out_load  = 1'b0;

        case (state_reg)
            S_RST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    if (stat.in_init)
                    begin
                        cmd.clr_start = 1'b1;
                        state_next    = S_INIT_CLR;
                    end
                    else if (stat.in_alloc)
                    begin
                        state_next = stat.alloc_empty ? S_REJ : S_SCAN;
                    end
                    else if (stat.in_rmw)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_REJ;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_found)
                begin
                    cmd.res_sel = RES_ALLOC;
                    state_next  = S_OUT;
                end
                else if (stat.scan_exhausted)
                begin
                    cmd.res_sel = RES_REJECT;
                    state_next  = S_OUT;
                end
            end
            S_RD:
            begin
                cmd.rmw_read = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.res_sel = RES_RMW;
                state_next  = S_OUT;
            end
            S_INIT_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.res_sel = RES_INIT;
                    state_next  = S_OUT;
                end
            end
            S_REJ:
            begin
                cmd.res_sel = RES_REJECT;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("item accepted without starting work");

    a_out_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("result handoff did not return to idle");

endmodule

`default_nettype wire

// ===== hdl/page_frame_refcount_allocator.sv =====
// Top level of the page frame allocator with per-page reference counts.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | in_item  (cmd, page_index)
//  out      | out_valid / out_stall| out_item (page_out, ref_count, free_count, status)
//  cfg      | cfg_we               | cfg_index, cfg_data (start_page, total_pages)
//
// One item at a time; the count memory has one write and one registered read port.
// Release, share, query in range: accept, read, modify-write, result handoff.
// Allocate: accept, a scan of the counts from start_page, then result handoff; the scan
// reads one count per cycle. Init: accept, clearing of all MEM_DEPTH counts, result handoff.
// After reset the whole count memory is cleared before the first item is taken.
// A result waits in the output register under out_stall while the next item is accepted.
`default_nettype none

module page_frame_refcount_allocator
    import pfra_pkg::*;
#(
    parameter int MAX_PAGES = PFRA_MAX_PAGES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire pfra_in_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pfra_out_t        out_item,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data
);

    pfra_cmd_t  cmd;
    pfra_stat_t stat;

    pfra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfra_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
